// ===== rtl/core/mcr_pkg.sv =====
package mcr_pkg;

   localparam logic MODE_STEP  = 1'b0;
   localparam logic MODE_START = 1'b1;

   localparam int POINT_COUNT = 8;
   localparam int CNT_BITS    = $clog2(POINT_COUNT);
   localparam logic [CNT_BITS-1:0] LAST_POINT = CNT_BITS'(POINT_COUNT - 1);

   localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/mcr_front.sv =====
module mcr_front
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int JOB_BITS   = 4 * COORD_BITS + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [COORD_BITS-1:0]   req_center_x,
   input  logic [COORD_BITS-1:0]   req_center_y,
   input  logic [COORD_BITS-2:0]   req_radius,
   output logic                    queue_push,
   input  logic                    queue_full,
   output logic [JOB_BITS-1:0]     push_data
);

   localparam int YW = COORD_BITS + 1;
   localparam int CW = COORD_BITS + 2;
   localparam int DW = COORD_BITS + 3;

   logic [COORD_BITS-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_BITS-1:0]   ox_ff, ox_in;
   logic signed [YW-1:0]    oy_ff, oy_in;
   logic signed [DW-1:0]    d_ff, d_in;
   logic                    active_ff, active_in;

   logic                    accept;
   logic                    step_go;
   logic [COORD_BITS-1:0]   nx;
   logic signed [YW-1:0]    ny;
   logic signed [CW-1:0]    nx_w, ny_w;
   logic signed [DW-1:0]    d_next;
   logic                    done;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !req_stall;
   assign step_go    = accept && (req_mode == MODE_STEP) && active_ff;
   assign queue_push = step_go;

   always_comb begin
      nx   = ox_ff + COORD_BITS'(1);
      ny   = oy_ff;
      nx_w = signed'({2'b00, nx});
      if (d_ff[DW-1]) begin
         d_next = d_ff + signed'(DW'({nx_w, 1'b1}));
      end else begin
         ny     = oy_ff - YW'(1);
         d_next = d_ff + signed'({CW'(nx_w - CW'(ny)), 1'b1});
      end
      ny_w = CW'(ny);
      done = nx_w > ny_w;
   end

   assign push_data = {done, cx_ff, cy_ff, ox_ff, oy_ff};

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      d_in      = d_ff;
      active_in = active_ff;
      if (accept && (req_mode == MODE_START)) begin
         cx_in     = req_center_x;
         cy_in     = req_center_y;
         ox_in     = '0;
         oy_in     = signed'({2'b00, req_radius});
         d_in      = DW'(1) - signed'({4'b0000, req_radius});
         active_in = 1'b1;
      end else if (step_go) begin
         ox_in     = nx;
         oy_in     = ny;
         d_in      = d_next;
         active_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         d_ff      <= '0;
         active_ff <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         d_ff      <= d_in;
         active_ff <= active_in;
      end
   end

endmodule

// ===== rtl/core/mcr_queue.sv =====
module mcr_queue
   import mcr_pkg::*;
#(
   parameter int JOB_BITS = 42
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_push,
   output logic                 queue_full,
   input  logic [JOB_BITS-1:0]  push_data,
   output logic                 pop_valid,
   input  logic                 pop_take,
   output logic [JOB_BITS-1:0]  pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [JOB_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic                do_pop;

   assign queue_full = (cnt_ff == NW'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_pop     = pop_take && pop_valid;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (queue_push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      priority if (queue_push && !do_pop) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (do_pop && !queue_push) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (queue_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/mcr_back.sv =====
module mcr_back
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int JOB_BITS   = 4 * COORD_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_take,
   input  logic [JOB_BITS-1:0]           pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_point_x,
   output logic signed [COORD_BITS+1:0]  rsp_point_y,
   output logic                          rsp_last_of_group,
   output logic                          rsp_circle_end
);

   localparam int YW = COORD_BITS + 1;
   localparam int CW = COORD_BITS + 2;

   logic [JOB_BITS-1:0]   job_ff, job_in;
   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic signed [CW-1:0]  px_ff, px_in, py_ff, py_in;
   logic                  last_ff, last_in, end_ff, end_in;

   logic                  job_end;
   logic [COORD_BITS-1:0] j_cx, j_cy, j_a;
   logic signed [YW-1:0]  j_b;
   logic signed [CW-1:0]  cx_w, cy_w, a_w, b_w, u_w, v_w;
   logic                  adv, emit, last_pt;

   assign {job_end, j_cx, j_cy, j_a, j_b} = job_ff;

   assign adv      = !valid_ff || !rsp_stall;
   assign emit     = busy_ff && adv;
   assign last_pt  = (cnt_ff == LAST_POINT);
   assign pop_take = pop_valid && (!busy_ff || (emit && last_pt));

   always_comb begin
      cx_w = signed'({2'b00, j_cx});
      cy_w = signed'({2'b00, j_cy});
      a_w  = signed'({2'b00, j_a});
      b_w  = CW'(j_b);
      u_w  = cnt_ff[2] ? b_w : a_w;
      v_w  = cnt_ff[2] ? a_w : b_w;
      px_in = cnt_ff[1] ? cx_w - u_w : cx_w + u_w;
      py_in = cnt_ff[0] ? cy_w - v_w : cy_w + v_w;
      last_in = last_pt;
      end_in  = last_pt && job_end;
   end

   always_comb begin
      job_in   = pop_take ? pop_data : job_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      valid_in = adv ? emit : valid_ff;
      if (emit) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (last_pt) begin
            busy_in = 1'b0;
         end
      end
      if (pop_take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         last_ff <= last_in;
         end_ff  <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_point_x       = px_ff;
   assign rsp_point_y       = py_ff;
   assign rsp_last_of_group = last_ff;
   assign rsp_circle_end    = end_ff;

endmodule

// ===== rtl/core/midpoint_circle_rasterizer_top.sv =====
// a step transaction passes the queue, the job register and the output register before its first point shows
// each step yields eight points, one point per cycle from the output register while rsp_stall is low
// start transactions emit nothing; the queue holds up to 2 steps
// reset is synchronous and active high; it idles the walk and empties the queue
module midpoint_circle_rasterizer_top
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [COORD_BITS-1:0]         req_center_x,
   input  logic [COORD_BITS-1:0]         req_center_y,
   input  logic [COORD_BITS-2:0]         req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_point_x,
   output logic signed [COORD_BITS+1:0]  rsp_point_y,
   output logic                          rsp_last_of_group,
   output logic                          rsp_circle_end
);

   localparam int JOB_BITS = 4 * COORD_BITS + 2;

   logic                queue_push;
   logic                queue_full;
   logic [JOB_BITS-1:0] push_data;
   logic [JOB_BITS-1:0] pop_data;
   logic                pop_valid;
   logic                pop_take;

   mcr_front #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .queue_push   (queue_push),
      .queue_full   (queue_full),
      .push_data    (push_data)
   );

   mcr_queue #(
      .JOB_BITS (JOB_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_push (queue_push),
      .queue_full (queue_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   mcr_back #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_take          (pop_take),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_circle_end    (rsp_circle_end)
   );

endmodule

// ===== rtl/core/mcr_checker.sv =====
module mcr_checker #(
   parameter int COORD_BITS = 10
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS+1:0]  rsp_point_x,
   input logic signed [COORD_BITS+1:0]  rsp_point_y,
   input logic                          rsp_last_of_group,
   input logic                          rsp_circle_end
);

   // a stalled point holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_last_of_group)
         && $stable(rsp_circle_end))
      else $error("stalled point changed");

   // circle end only on the closing point of a group
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_circle_end |-> rsp_last_of_group)
      else $error("circle end without group end");

   // nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("point shown after reset");

   // points of one group leave back to back
   a_group_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_group |=> rsp_valid)
      else $error("gap inside a group");

   // a full queue means the back is showing a point
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while output idle");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker #(
   .COORD_BITS (COORD_BITS)
) u_mcr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_point_x       (rsp_point_x),
   .rsp_point_y       (rsp_point_y),
   .rsp_last_of_group (rsp_last_of_group),
   .rsp_circle_end    (rsp_circle_end)
);

// ===== tb/tb.sv =====
module tb
   import mcr_pkg::*;
();

   localparam int CB = 10;

   typedef struct {
      logic          mode;
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-2:0] r;
   } circle_cmd_type;

   typedef struct {
      logic signed [CB+1:0] x;
      logic signed [CB+1:0] y;
      logic                 last;
      logic                 cend;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = MODE_STEP;
   logic [CB-1:0]         req_center_x = '0;
   logic [CB-1:0]         req_center_y = '0;
   logic [CB-2:0]         req_radius = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [CB+1:0]  rsp_point_x;
   logic signed [CB+1:0]  rsp_point_y;
   logic                  rsp_last_of_group;
   logic                  rsp_circle_end;

   circle_cmd_type cmd_q[$];
   circle_cmd_type cmd;
   pixel_type      pixel_q[$];

   // predictor state
   logic [CB-1:0] circ_cx = '0;
   logic [CB-1:0] circ_cy = '0;
   int            walk_x = 0;
   int            walk_y = 0;
   int            walk_d = 0;
   bit            walking = 1'b0;

   bit req_taken = 1'b0;
   bit no_idle = 1'b0;
   int calm_cnt = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   int total_cmds = 0;
   int n_accepted = 0;
   int n_points = 0;
   int n_circles = 0;
   int n_starts = 0;
   int fail_count = 0;

   midpoint_circle_rasterizer_top #(.COORD_BITS(CB)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_circle_end    (rsp_circle_end)
   );

   always #5 clock = ~clock;

   // number of steps that close a circle of radius r
   function automatic int walk_len(input int r);
      int x, y, d, n;
      x = 0;
      y = r;
      d = 1 - r;
      n = 0;
      do begin
         x++;
         if (d < 0) begin
            d += 2 * x + 1;
         end else begin
            y--;
            d += 2 * (x - y) + 1;
         end
         n++;
      end while (x <= y);
      return n;
   endfunction

   task automatic queue_start(input int cx, input int cy, input int r);
      circle_cmd_type c;
      c.mode = MODE_START;
      c.cx   = cx[CB-1:0];
      c.cy   = cy[CB-1:0];
      c.r    = r[CB-2:0];
      cmd_q.push_back(c);
   endtask

   // step fields other than mode are ignored, so fill them with noise
   task automatic queue_step();
      circle_cmd_type c;
      c.mode = MODE_STEP;
      c.cx   = CB'($urandom);
      c.cy   = CB'($urandom);
      c.r    = (CB-1)'($urandom);
      cmd_q.push_back(c);
   endtask

   task automatic trace_step(input circle_cmd_type c);
      int        a, b, ox, oy;
      int        px[POINT_COUNT];
      int        py[POINT_COUNT];
      bit        fin;
      pixel_type p;
      if (c.mode == MODE_START) begin
         circ_cx = c.cx;
         circ_cy = c.cy;
         walk_x  = 0;
         walk_y  = c.r;
         walk_d  = 1 - int'(c.r);
         walking = 1'b1;
         n_starts++;
      end else if (walking) begin
         a  = walk_x;
         b  = walk_y;
         ox = circ_cx;
         oy = circ_cy;
         walk_x = a + 1;
         if (walk_d < 0) begin
            walk_d += 2 * walk_x + 1;
         end else begin
            walk_y = b - 1;
            walk_d += 2 * (walk_x - walk_y) + 1;
         end
         fin = walk_x > walk_y;
         if (fin) walking = 1'b0;
         px = '{ox + a, ox + a, ox - a, ox - a, ox + b, ox + b, ox - b, ox - b};
         py = '{oy + b, oy - b, oy + b, oy - b, oy + a, oy - a, oy + a, oy - a};
         for (int k = 0; k < POINT_COUNT; k++) begin
            p.x    = px[k][CB+1:0];
            p.y    = py[k][CB+1:0];
            p.last = (k == POINT_COUNT - 1);
            p.cend = (k == POINT_COUNT - 1) && fin;
            pixel_q.push_back(p);
         end
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // idle pacing: calm stretches, and none at all towards the end
   always @(posedge clock) begin
      if (calm_cnt > 0) begin
         calm_cnt--;
      end else if ($urandom_range(0, 299) == 0) begin
         calm_cnt = $urandom_range(50, 200);
      end
      no_idle = (calm_cnt > 0) || (cmd_q.size() < 40);
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(1, 13) - 1;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            cmd = cmd_q.pop_front();
            req_valid    <= 1'b1;
            req_mode     <= cmd.mode;
            req_center_x <= cmd.cx;
            req_center_y <= cmd.cy;
            req_radius   <= cmd.r;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(1, 13);
      end
      rsp_stall <= (rsp_hold > 0);
   end

   // monitor
   always @(posedge clock) begin
      circle_cmd_type c;
      pixel_type      p;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            c.mode = req_mode;
            c.cx   = req_center_x;
            c.cy   = req_center_y;
            c.r    = req_radius;
            trace_step(c);
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_points++;
            if (rsp_circle_end) n_circles++;
            if (pixel_q.size() == 0) begin
               $error("unexpected point (%0d,%0d) with nothing pending",
                      rsp_point_x, rsp_point_y);
               fail_count++;
            end else begin
               p = pixel_q.pop_front();
               compare_field("point_x", p.x, rsp_point_x);
               compare_field("point_y", p.y, rsp_point_y);
               compare_field("last_of_group", p.last, rsp_last_of_group);
               compare_field("circle_end", p.cend, rsp_circle_end);
            end
         end
      end
   end

   initial begin
      int  counted, kind, r, n;
      bit  idle_now;

      // directed: idle step, zero radius, corners, abandonment, two small full walks
      queue_step();
      queue_start(0, 0, 0);
      queue_step();
      queue_step();
      queue_start(1023, 1023, 1);
      queue_step();
      queue_start(0, 1023, 511);
      queue_step();
      queue_step();
      queue_start(1023, 0, 511);
      queue_step();
      queue_step();
      queue_start(0, 0, 3);
      repeat (walk_len(3)) queue_step();
      queue_start(512, 341, 5);
      repeat (walk_len(5)) queue_step();

      counted = 0;
      idle_now = 1'b1;
      while (counted < 275) begin
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
            queue_start($urandom_range(0, 1023), $urandom_range(0, 1023), r);
            n = walk_len(r);
            repeat (n) queue_step();
            counted += n + 1;
            idle_now = 1'b1;
         end else if (kind < 17) begin
            r = $urandom_range(0, 511);
            n = walk_len(r) - 1;
            if (n > 6) n = 6;
            n = $urandom_range(0, n);
            queue_start($urandom_range(0, 1023), $urandom_range(0, 1023), r);
            repeat (n) queue_step();
            counted += n + 1;
            idle_now = 1'b0;
         end else if (idle_now) begin
            repeat ($urandom_range(1, 3)) queue_step();
         end else begin
            queue_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 511));
            counted++;
         end
      end
      total_cmds = cmd_q.size();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      wait (n_accepted == total_cmds);
      wait (pixel_q.size() == 0);
      repeat (20) @(posedge clock);

      $display("%0d transactions sent (%0d circle starts)", n_accepted, n_starts);
      $display("%0d points checked, %0d circles closed", n_points, n_circles);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mcr_pkg.sv
rtl/core/mcr_front.sv
rtl/core/mcr_queue.sv
rtl/core/mcr_back.sv
rtl/core/midpoint_circle_rasterizer_top.sv
rtl/core/mcr_checker.sv
tb/tb.sv
